// ===== rtl/ddo_pkg.sv =====
// shared types, constants and tables for the differential drive odometry block
`default_nettype none

package ddo_pkg;

	localparam int CFG_IDX_W        = 1;
	localparam int CFG_DATA_W       = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int TAB_LEN          = 24;
	localparam int ITER_W           = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_HALF_WHEEL_RADIUS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_OVER_TRACK = 1'd1;

	localparam logic [15:0] HALF_WHEEL_RADIUS_RST = 16'd3277;
	localparam logic [15:0] RADIUS_OVER_TRACK_RST = 16'd13107;

	// cordic start vector, gain compensated, q30
	localparam logic signed [31:0] CORDIC_GAIN  = 32'sd652032874;
	// low word of 2*pi in q30; the full constant is 2^32 plus this
	localparam logic [31:0]        ANG_SCALE_LO = 32'd2451551556;
	// 2^32 / (2*pi)
	localparam logic [31:0]        TURN_PER_RAD = 32'd683565276;

	typedef struct packed {
		logic signed [15:0] first_wheel_speed;
		logic signed [15:0] second_wheel_speed;
		logic [15:0]        time_step;
	} ddo_in_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [15:0]        heading;
	} ddo_out_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_ANG,
		OP_INIT,
		OP_PM,
		OP_HA,
		OP_HB,
		OP_QS,
		OP_QM,
		OP_QR,
		OP_ROT,
		OP_MX,
		OP_MY,
		OP_UY,
		OP_EMIT
	} ddo_op_t;

	typedef struct packed {
		ddo_op_t           op;
		logic [ITER_W-1:0] iter;
	} ddo_cmd_t;

	// arctangent of 2^-i in q30 radians
	function automatic logic [29:0] atan_q30(input logic [ITER_W-1:0] i);
		logic [29:0] r;
		unique case (i)
			5'd0:    r = 30'd843314857;
			5'd1:    r = 30'd497837829;
			5'd2:    r = 30'd263043837;
			5'd3:    r = 30'd133525159;
			5'd4:    r = 30'd67021687;
			5'd5:    r = 30'd33543516;
			5'd6:    r = 30'd16775851;
			5'd7:    r = 30'd8388437;
			5'd8:    r = 30'd4194283;
			5'd9:    r = 30'd2097149;
			5'd10:   r = 30'd1048576;
			5'd11:   r = 30'd524288;
			5'd12:   r = 30'd262144;
			5'd13:   r = 30'd131072;
			5'd14:   r = 30'd65536;
			5'd15:   r = 30'd32768;
			5'd16:   r = 30'd16384;
			5'd17:   r = 30'd8192;
			5'd18:   r = 30'd4096;
			5'd19:   r = 30'd2048;
			5'd20:   r = 30'd1024;
			5'd21:   r = 30'd512;
			5'd22:   r = 30'd256;
			5'd23:   r = 30'd128;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/differential_drive_odometry.sv =====
// top level of the differential drive odometry block
//
//  channel   direction  handshake            payload
//  in        input      in_valid/in_ready    in_data  (wheel speeds, time step)
//  out       output     out_valid/out_ready  out_data (x, y, heading)
//  cfg       input      cfg_we               cfg_index, cfg_data
//
//  on the way from accept to the output register, the cordic rotation loop does
//  most of the work at the default CORDIC_STEPS; most of the other steps are
//  products through the single shared multiplier
//  reset clears the pose to zero and loads the register defaults
//  a new beat is taken the cycle after the previous pose reaches the output register;
//  the final load waits while the output register holds an untaken beat
`default_nettype none

module differential_drive_odometry #(
	parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  ddo_pkg::ddo_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output ddo_pkg::ddo_out_t              out_data,
	input  logic                           cfg_we,
	input  logic [ddo_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ddo_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ddo_pkg::*;

	ddo_cmd_t cmd;

	ddo_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	ddo_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (out_data)
	);

`ifndef ASSERT_OFF
	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_LOAD) |-> (in_valid && in_ready))
		else $error("input loaded without an accepted beat");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second beat taken while an item is in work");

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EMIT) |=> out_valid)
		else $error("result loaded but output not valid");
`endif

endmodule

`default_nettype wire

// ===== rtl/ddo_ctrl.sv =====
// sequencer for the odometry datapath: one micro-op per cycle, none while the final load waits on a stalled output
`default_nettype none

module ddo_ctrl #(
	parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output ddo_pkg::ddo_cmd_t cmd
);
	import ddo_pkg::*;

	localparam int ROT_N = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ROT_N - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ANG,
		S_INIT,
		S_PM,
		S_HA,
		S_HB,
		S_QS,
		S_QM,
		S_QR,
		S_ROT,
		S_MX,
		S_MY,
		S_UY,
		S_EMIT
	} state_t;

	state_t            state_q;
	logic [ITER_W-1:0] iter_q;
	logic              out_valid_q;
	logic              emit_ok;

	assign emit_ok   = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_EMIT) && emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_ANG;
					end
				end
				S_ANG:  state_q <= S_INIT;
				S_INIT: state_q <= S_PM;
				S_PM:   state_q <= S_HA;
				S_HA:   state_q <= S_HB;
				S_HB:   state_q <= S_QS;
				S_QS:   state_q <= S_QM;
				S_QM:   state_q <= S_QR;
				S_QR: begin
					iter_q  <= '0;
					state_q <= S_ROT;
				end
				S_ROT: begin
					if (iter_q == ITER_LAST) begin
						state_q <= S_MX;
					end else begin
						iter_q <= iter_q + 1'b1;
					end
				end
				S_MX: state_q <= S_MY;
				S_MY: state_q <= S_UY;
				S_UY: state_q <= S_EMIT;
				S_EMIT: begin
					if (emit_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.iter = iter_q;
		unique case (state_q)
			S_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
			S_ANG:   cmd.op = OP_ANG;
			S_INIT:  cmd.op = OP_INIT;
			S_PM:    cmd.op = OP_PM;
			S_HA:    cmd.op = OP_HA;
			S_HB:    cmd.op = OP_HB;
			S_QS:    cmd.op = OP_QS;
			S_QM:    cmd.op = OP_QM;
			S_QR:    cmd.op = OP_QR;
			S_ROT:   cmd.op = OP_ROT;
			S_MX:    cmd.op = OP_MX;
			S_MY:    cmd.op = OP_MY;
			S_UY:    cmd.op = OP_UY;
			S_EMIT:  cmd.op = emit_ok ? OP_EMIT : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/ddo_datapath.sv =====
// pose registers, shared multiplier, cordic rotator and config registers
`default_nettype none

module ddo_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ddo_pkg::ddo_cmd_t                  cmd,
	input  ddo_pkg::ddo_in_t                   in_data,
	input  logic                               cfg_we,
	input  logic [ddo_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ddo_pkg::CFG_DATA_W-1:0]     cfg_data,
	output ddo_pkg::ddo_out_t                  out_data
);
	import ddo_pkg::*;

	// config and pose
	logic [15:0] half_wheel_radius_q;
	logic [15:0] radius_over_track_q;
	logic [31:0] x_pos_q;
	logic [31:0] y_pos_q;
	logic [15:0] heading_q;

	// per-item working registers
	logic [15:0] dmag_q;
	logic        dneg_q;
	logic [16:0] smag_q;
	logic        sneg_q;
	logic [15:0] dt_q;
	logic        flip_q;
	logic [14:0] amag_q;
	logic        aneg_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [23:0] bfrac_q;
	logic [30:0] qr_q;
	logic signed [31:0] cx_q;
	logic signed [31:0] cy_q;
	logic signed [33:0] cz_q;
	ddo_out_t    out_q;

	// input conditioning
	logic signed [16:0] diff;
	logic signed [16:0] sum;
	logic [16:0]        dabs;
	logic [16:0]        sabs;
	logic [15:0]        hrot;
	logic [15:0]        afold;
	logic [15:0]        aabs;

	assign diff = {in_data.first_wheel_speed[15], in_data.first_wheel_speed}
	            - {in_data.second_wheel_speed[15], in_data.second_wheel_speed};
	assign sum  = {in_data.first_wheel_speed[15], in_data.first_wheel_speed}
	            + {in_data.second_wheel_speed[15], in_data.second_wheel_speed};
	assign dabs = diff[16] ? 17'(-diff) : 17'(diff);
	assign sabs = sum[16] ? 17'(-sum) : 17'(sum);

	// fold heading by a half turn into [-1/4, 1/4)
	assign hrot  = heading_q + 16'd16384;
	assign afold = hrot[15] ? (heading_q + 16'h8000) : heading_q;
	assign aabs  = afold[15] ? 16'(-afold) : afold;

	// shared multiplier
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [31:0] xabs;
	logic [31:0] yabs;

	assign xabs = cx_q[31] ? 32'(-cx_q) : 32'(cx_q);
	assign yabs = cy_q[31] ? 32'(-cy_q) : 32'(cy_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_ANG: begin
				mul_a = {17'd0, amag_q};
				mul_b = ANG_SCALE_LO;
			end
			OP_INIT: begin
				mul_a = {16'd0, dmag_q};
				mul_b = {16'd0, radius_over_track_q};
			end
			OP_PM, OP_QM: begin
				mul_a = prod_q[31:0];
				mul_b = {16'd0, dt_q};
			end
			OP_HA: begin
				mul_a = {8'd0, prod_q[47:24]};
				mul_b = TURN_PER_RAD;
			end
			OP_HB: begin
				mul_a = {8'd0, bfrac_q};
				mul_b = TURN_PER_RAD;
			end
			OP_QS: begin
				mul_a = {15'd0, smag_q};
				mul_b = {16'd0, half_wheel_radius_q};
			end
			OP_MX: begin
				mul_a = {1'b0, qr_q};
				mul_b = xabs;
			end
			OP_MY: begin
				mul_a = {1'b0, qr_q};
				mul_b = yabs;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = 64'(mul_a) * 64'(mul_b);

	// angle to q30 radians
	logic [47:0]        zsum;
	logic [31:0]        zmag;
	logic signed [33:0] z_init;

	assign zsum   = prod_q[47:0] + {1'b0, amag_q, 32'd0} + 48'd32768;
	assign zmag   = zsum[47:16];
	assign z_init = aneg_q ? -$signed({2'b00, zmag}) : $signed({2'b00, zmag});

	// heading step
	logic [63:0] hsum;
	logic [15:0] delta;

	assign hsum  = acc_q + 64'h2_0000_0000 + {24'd0, prod_q[63:24]};
	assign delta = hsum[49:34];

	// travel rounding
	logic [48:0] qsum;

	assign qsum = {1'b0, prod_q[47:0]} + 49'h2_0000;

	// cordic micro-rotation
	logic signed [31:0] xs;
	logic signed [31:0] ys;
	logic signed [33:0] atan_ext;

	assign xs       = cx_q >>> cmd.iter;
	assign ys       = cy_q >>> cmd.iter;
	assign atan_ext = $signed({4'd0, atan_q30(cmd.iter)});

	// scaled move
	logic [63:0] msum;
	logic [31:0] mval;
	logic        negx;
	logic        negy;

	assign msum = prod_q + (64'd1 << 37);
	assign mval = {6'd0, msum[63:38]};
	assign negx = sneg_q ^ cx_q[31] ^ flip_q;
	assign negy = sneg_q ^ cy_q[31] ^ flip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_wheel_radius_q <= HALF_WHEEL_RADIUS_RST;
			radius_over_track_q <= RADIUS_OVER_TRACK_RST;
			x_pos_q             <= '0;
			y_pos_q             <= '0;
			heading_q           <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_HALF_WHEEL_RADIUS: half_wheel_radius_q <= cfg_data;
					CFG_RADIUS_OVER_TRACK: radius_over_track_q <= cfg_data;
					default: ;
				endcase
			end
			case (cmd.op)
				OP_QS: heading_q <= dneg_q ? (heading_q - delta) : (heading_q + delta);
				OP_MY: x_pos_q   <= x_pos_q + (negx ? 32'(-mval) : mval);
				OP_UY: y_pos_q   <= y_pos_q + (negy ? 32'(-mval) : mval);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (cmd.op)
			OP_LOAD: begin
				dmag_q <= dabs[15:0];
				dneg_q <= diff[16];
				smag_q <= sabs;
				sneg_q <= sum[16];
				dt_q   <= in_data.time_step;
				flip_q <= hrot[15];
				amag_q <= aabs[14:0];
				aneg_q <= afold[15];
			end
			OP_INIT: begin
				cx_q <= CORDIC_GAIN;
				cy_q <= '0;
				cz_q <= z_init;
			end
			OP_HA: bfrac_q <= prod_q[23:0];
			OP_HB: acc_q   <= prod_q;
			OP_QR: qr_q    <= qsum[48:18];
			OP_ROT: begin
				if (!cz_q[33]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - atan_ext;
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + atan_ext;
				end
			end
			OP_EMIT: begin
				out_q.pos_x   <= $signed(x_pos_q);
				out_q.pos_y   <= $signed(y_pos_q);
				out_q.heading <= heading_q;
			end
			default: ;
		endcase
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for the differential drive odometry block
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ddo_pkg::*;

	localparam int CORDIC_STEPS = CORDIC_STEPS_DEF;
	localparam int CORDIC_ITERS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
	localparam longint CORDIC_START = 64'sd652032874;
	localparam longint unsigned RAD_PER_TURN_Q30 = 64'd6746518852;
	localparam longint unsigned TURNS_PER_RAD = 64'd683565276;
	localparam longint ARCTAN_Q30 [24] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128
	};
	localparam int WATCHDOG_CYCLES = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	ddo_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	ddo_out_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [31:0] x_pose;
	logic [31:0] y_pose;
	logic [15:0] heading_pose;
	logic [15:0] half_radius;
	logic [15:0] track_ratio;

	ddo_in_t wheel_q [$];
	ddo_out_t pose_q [$];
	ddo_out_t want;
	bit in_took;
	bit allow_idle = 1'b1;
	bit hold_req;
	bit failed;
	int send_gap;
	int take_gap;
	int hold_left;
	int idle_cycles;

	differential_drive_odometry #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void heading_vector(input logic [15:0] ang, output longint c,
			output longint s);
		logic [15:0] shifted;
		logic [15:0] folded;
		bit flip;
		longint sa;
		longint z;
		longint x;
		longint y;
		longint xs;
		longint ys;
		longint unsigned mag;
		shifted = ang + 16'd16384;
		flip = shifted[15];
		folded = flip ? ang + 16'd32768 : ang;
		sa = signed'(folded);
		mag = (sa < 0) ? -sa : sa;
		mag = (mag * RAD_PER_TURN_Q30 + 64'd32768) >> 16;
		z = mag;
		if (sa < 0) begin
			z = -z;
		end
		x = CORDIC_START;
		y = 0;
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - ARCTAN_Q30[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + ARCTAN_Q30[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = x;
		s = y;
	endfunction

	// distance in 2^-24 m times a q30 trig value, rounded to 2^-16 m
	function automatic logic [31:0] along_axis(input longint unsigned span, input bit back,
			input longint t);
		longint unsigned tm;
		longint unsigned m;
		tm = (t < 0) ? -t : t;
		m = (span * tm + (64'd1 << 37)) >> 38;
		return (back != (t < 0)) ? 32'd0 - m[31:0] : m[31:0];
	endfunction

	function automatic ddo_out_t advance_pose(input ddo_in_t beat);
		longint w1;
		longint w2;
		longint turn;
		longint travel;
		longint unsigned turn_mag;
		longint unsigned travel_mag;
		longint unsigned dt;
		longint unsigned pm;
		longint unsigned acc;
		longint unsigned span;
		longint c;
		longint s;
		logic [15:0] dh;
		ddo_out_t r;
		w1 = signed'(beat.first_wheel_speed);
		w2 = signed'(beat.second_wheel_speed);
		dt = beat.time_step;
		turn = w1 - w2;
		travel = w1 + w2;
		turn_mag = (turn < 0) ? -turn : turn;
		travel_mag = (travel < 0) ? -travel : travel;
		pm = turn_mag * track_ratio * dt;
		acc = (pm >> 24) * TURNS_PER_RAD + (64'd1 << 33)
			+ (((pm & 64'hFFFFFF) * TURNS_PER_RAD) >> 24);
		dh = 16'(acc >> 34);
		heading_vector(heading_pose, c, s);
		span = (travel_mag * half_radius * dt + (64'd1 << 17)) >> 18;
		x_pose = x_pose + along_axis(span, travel < 0, c);
		y_pose = y_pose + along_axis(span, travel < 0, s);
		heading_pose = (turn < 0) ? heading_pose - dh : heading_pose + dh;
		r.pos_x = x_pose;
		r.pos_y = y_pose;
		r.heading = heading_pose;
		return r;
	endfunction

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0000;
			4: return 16'($urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void queue_beat(input logic [15:0] w1, input logic [15:0] w2,
			input logic [15:0] dt);
		ddo_in_t b;
		b.first_wheel_speed = w1;
		b.second_wheel_speed = w2;
		b.time_step = dt;
		wheel_q.push_back(b);
	endfunction

	function automatic void queue_random(input int count);
		for (int i = 0; i < count; i++) begin
			queue_beat(pick_word(), pick_word(), pick_word());
		end
	endfunction

	task automatic program_regs(input logic [15:0] hwr, input logic [15:0] rot);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_HALF_WHEEL_RADIUS;
		cfg_data <= hwr;
		@(negedge clk);
		cfg_index <= CFG_RADIUS_OVER_TRACK;
		cfg_data <= rot;
		@(negedge clk);
		cfg_we <= 1'b0;
		half_radius = hwr;
		track_ratio = rot;
	endtask

	task automatic drain();
		do @(posedge clk);
		while (wheel_q.size() != 0 || in_valid || pose_q.size() != 0);
	endtask

	// sender: one beat at a time, random gaps between beats
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			in_took = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (allow_idle && $urandom_range(0, 7) == 0) begin
				send_gap = $urandom_range(0, 3);
				in_valid <= 1'b0;
			end else if (wheel_q.size() != 0) begin
				in_data <= wheel_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off on request
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (take_gap > 0) begin
				take_gap--;
				out_ready <= 1'b0;
			end else if (allow_idle && $urandom_range(0, 7) == 0) begin
				take_gap = $urandom_range(0, 3);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			idle_cycles++;
			if (in_valid && in_ready) begin
				pose_q.push_back(advance_pose(in_data));
				in_took = 1'b1;
				idle_cycles = 0;
			end
			if (out_valid && out_ready) begin
				idle_cycles = 0;
				if (pose_q.size() == 0) begin
					$error("pose beat with none expected: x %0d y %0d heading %0d",
						out_data.pos_x, out_data.pos_y, out_data.heading);
					failed = 1'b1;
				end else begin
					want = pose_q.pop_front();
					if (out_data.pos_x !== want.pos_x) begin
						$error("pos_x: expected %0d, got %0d", want.pos_x, out_data.pos_x);
						failed = 1'b1;
					end
					if (out_data.pos_y !== want.pos_y) begin
						$error("pos_y: expected %0d, got %0d", want.pos_y, out_data.pos_y);
						failed = 1'b1;
					end
					if (out_data.heading !== want.heading) begin
						$error("heading: expected %0d, got %0d", want.heading,
							out_data.heading);
						failed = 1'b1;
					end
				end
			end
			if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		logic [15:0] goal;
		logic signed [15:0] offset;
		int steer;
		x_pose = '0;
		y_pose = '0;
		heading_pose = '0;
		half_radius = HALF_WHEEL_RADIUS_RST;
		track_ratio = RADIUS_OVER_TRACK_RST;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed beats at the reset register values
		queue_beat(16'd0, 16'd0, 16'd0);
		queue_beat(16'h7FFF, 16'h7FFF, 16'hFFFF);
		queue_beat(16'h8000, 16'h8000, 16'hFFFF);
		queue_beat(16'h7FFF, 16'h8000, 16'hFFFF);
		queue_beat(16'h8000, 16'h7FFF, 16'hFFFF);
		queue_beat(16'd1000, 16'd500, 16'd0);
		queue_beat(16'hFFFF, 16'd0, 16'd1);
		queue_beat(16'd0, 16'd0, 16'hFFFF);
		for (int i = 0; i < 7; i++) begin
			queue_beat(16'd9000, -16'sd7000, 16'd40000);
		end
		for (int i = 0; i < 3; i++) begin
			queue_beat(-16'sd6000, 16'd9000, 16'd50000);
		end
		queue_beat(16'h7FFF, 16'h7FFF, 16'h8000);
		queue_beat(16'h8000, 16'd0, 16'h7FFF);
		drain();

		// turn the heading onto the nearest axis, no travel
		program_regs(16'd0, 16'hFFFF);
		goal = (heading_pose + 16'd8192) & 16'hC000;
		offset = goal - heading_pose;
		steer = int'(offset) * 100 / 1019;
		queue_beat(16'(steer), 16'd0, 16'hFFFF);
		drain();

		// long straight run at full scale until a position wraps
		program_regs(16'hFFFF, 16'd0);
		for (int i = 0; i < 560; i++) begin
			queue_beat(16'($urandom_range(31744, 32767)), 16'($urandom_range(31744, 32767)),
				16'($urandom_range(64512, 65535)));
		end
		drain();

		program_regs(16'($urandom), 16'($urandom));
		queue_random(150);
		drain();

		program_regs(16'hFFFF, 16'hFFFF);
		queue_random(120);
		@(posedge clk);
		hold_req = 1'b1;
		drain();

		program_regs(HALF_WHEEL_RADIUS_RST, RADIUS_OVER_TRACK_RST);
		queue_random(100);
		drain();

		allow_idle = 1'b0;
		program_regs(16'($urandom), 16'($urandom));
		queue_random(100);
		drain();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failed || pose_q.size() != 0) begin
			$display("Some tests failed");
		end else begin
			$display("All tests passed");
		end
		$finish;
	end

endmodule

// ===== differential_drive_odometry.f =====
rtl/ddo_pkg.sv
rtl/ddo_ctrl.sv
rtl/ddo_datapath.sv
rtl/differential_drive_odometry.sv
tb/tb_top.sv
